// ===== rtl/arm_ik_pkg.sv =====
// arm_ik_pkg: shared constants, tables and types of the arm inverse kinematics block
// depends on nothing; imported by rrr_arm_inverse_kinematics and arm_ik_cordic
`default_nettype none

package arm_ik_pkg;

   localparam int FRAC_BITS_DEF     = 8;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int COORD_W = 16;
   localparam int CFG_W   = 15;
   localparam int IDX_W   = 2;

   // angles count 2^-16 degree
   localparam int ANG_FRAC = 16;
   localparam int ANG_W    = 24;
   localparam int ACC_W    = 25;
   localparam int XY_W     = 34;

   localparam logic [ANG_W-1:0] DEG90  = 24'd5898240;
   localparam logic [ANG_W-1:0] DEG180 = 24'd11796480;

   // cordic operand magnitudes and normalizer
   localparam int CORDIC_W  = 48;
   localparam int NORM_BITS = 30;
   localparam int NORM_RSH  = $clog2(CORDIC_W - NORM_BITS + 1);
   localparam int NORM_LSH  = $clog2(NORM_BITS);

   localparam int ATAN_LEN = 24;
   localparam logic [21:0] ATAN_TAB [ATAN_LEN] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
      22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
   };

   localparam logic [CFG_W-1:0] UPPER_ARM_RST = 15'd973;
   localparam logic [CFG_W-1:0] FOREARM_RST   = 15'd1152;
   localparam logic [CFG_W-1:0] SHOULDER_RST  = 15'd896;

   typedef enum logic [IDX_W-1:0] {
      CSR_UPPER_ARM = 2'd0,
      CSR_FOREARM   = 2'd1,
      CSR_SHOULDER  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W:0]   s;
      logic signed [31:0]        n;
      logic [30:0]               m;
      logic                      reach;
   } geo_type;

   typedef struct packed {
      logic yneg;
      logic sneg;
      logic reach;
   } flag_type;

endpackage

`default_nettype wire

// ===== rtl/rrr_arm_inverse_kinematics.sv =====
// rrr_arm_inverse_kinematics: top level, elbow-down inverse kinematics of a yaw/shoulder/elbow arm
// depends on arm_ik_pkg, arm_ik_delay, arm_ik_isqrt, arm_ik_cordic
//
// usage: a request on req_ carries a target point (x, y, z), signed Q8.8, and gives exactly
// one response on rsp_ with base, shoulder and elbow angles in whole degrees plus a
// reachable flag in rsp_tuser; an out-of-reach target returns all angles zero.
// link lengths and shoulder height are written on csr_ (index 0 upper arm, 1 forearm,
// 2 shoulder height) while no request is in flight.
// throughput: one request per cycle unless stalled. depth: 11 register stages outside
// the square root row of 31 cells and the cordic (2 + 10 normalizer stages +
// CORDIC_STAGES cells). the 31-cell square root of m^2 - n^2 sets the depth;
// four cordic rows run side by side.
// reset clears the configuration to its defaults and empties the pipeline at once.
// when rsp_tready is low the response waits in the output register and one more in a
// skid register; once the skid holds data the whole pipeline and req_tready stall
// until the receiver takes a response.
`default_nettype none

module rrr_arm_inverse_kinematics
   import arm_ik_pkg::*;
#(
   parameter int FRAC_BITS     = FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [47:0]      req_tdata,  // target_x, target_y, target_z
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [31:0]      rsp_tdata,  // base_deg, shoulder_deg, elbow_deg, zero pad
   output logic                  rsp_tuser,  // reachable
   input  wire logic             csr_we,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   localparam int SQ_W     = 62;
   localparam int SN_CELLS = SQ_W / 2;
   localparam int RS_IN_W  = 2 * COORD_W + 2 * FRAC_BITS;
   localparam int RS_CELLS = RS_IN_W / 2;
   localparam int RS_DLY   = 4 + SN_CELLS - RS_CELLS;
   localparam int SIDE_DLY = 2 + SN_CELLS;
   localparam int CL       = 2 + NORM_RSH + NORM_LSH + CORDIC_STAGES;
   localparam int PL       = 10 + SN_CELLS + CL;
   localparam int OUT_W    = 27;

   logic en;
   logic req_acc;

   // configuration
   logic [CFG_W-1:0] l1_ff, l2_ff, h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_ff <= UPPER_ARM_RST;
         l2_ff <= FOREARM_RST;
         h_ff  <= SHOULDER_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_UPPER_ARM: l1_ff <= csr_wdata;
            CSR_FOREARM:   l2_ff <= csr_wdata;
            CSR_SHOULDER:  h_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid row
   logic [PL-1:0] vld_ff, vld_in;

   assign req_acc = req_tvalid && req_tready;
   assign vld_in  = {vld_ff[PL-2:0], req_acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage a: squares and the shoulder offset
   logic signed [COORD_W-1:0] tx, ty, tz;
   logic signed [31:0]        xx_full, yy_full;
   logic signed [COORD_W:0]   s_a_in, s_a_ff;
   logic [30:0]               xx_a_ff, yy_a_ff;
   logic [29:0]               l11_a_ff, l22_a_ff, l12_a_ff;
   logic signed [COORD_W-1:0] x_a_ff, y_a_ff;

   always_comb begin
      tx      = signed'(req_tdata[15:0]);
      ty      = signed'(req_tdata[31:16]);
      tz      = signed'(req_tdata[47:32]);
      xx_full = tx * tx;
      yy_full = ty * ty;
      s_a_in  = {tz[COORD_W-1], tz} - signed'({2'b00, h_ff});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_a_ff   <= s_a_in;
         xx_a_ff  <= xx_full[30:0];
         yy_a_ff  <= yy_full[30:0];
         l11_a_ff <= l1_ff * l1_ff;
         l22_a_ff <= l2_ff * l2_ff;
         l12_a_ff <= l1_ff * l2_ff;
         x_a_ff   <= tx;
         y_a_ff   <= ty;
      end
   end

   // stage b
   logic signed [33:0]        s2_full;
   logic [31:0]               rr_b_ff, s2_b_ff;
   logic [30:0]               lsum_b_ff, m_b_ff;
   logic signed [COORD_W:0]   s_b_ff;
   logic signed [COORD_W-1:0] x_b_ff, y_b_ff;

   assign s2_full = s_a_ff * s_a_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rr_b_ff   <= {1'b0, xx_a_ff} + {1'b0, yy_a_ff};
         s2_b_ff   <= s2_full[31:0];
         lsum_b_ff <= {1'b0, l11_a_ff} + {1'b0, l22_a_ff};
         m_b_ff    <= {l12_a_ff, 1'b0};
         s_b_ff    <= s_a_ff;
         x_b_ff    <= x_a_ff;
         y_b_ff    <= y_a_ff;
      end
   end

   // stage c: numerator of the elbow cosine
   logic signed [34:0]        n_c_ff;
   logic [30:0]               m_c_ff;
   logic signed [COORD_W:0]   s_c_ff;
   logic signed [COORD_W-1:0] x_c_ff, y_c_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         n_c_ff <= signed'({3'b000, rr_b_ff}) + signed'({3'b000, s2_b_ff})
                   - signed'({4'b0000, lsum_b_ff});
         m_c_ff <= m_b_ff;
         s_c_ff <= s_b_ff;
         x_c_ff <= x_b_ff;
         y_c_ff <= y_b_ff;
      end
   end

   // stage d: reach test
   logic signed [34:0] m_wide;
   logic [34:0]        n_abs;
   logic               reach_d_in;
   logic [30:0]        na_d_ff;
   geo_type            geo_d_ff;

   always_comb begin
      m_wide     = signed'({4'b0000, m_c_ff});
      n_abs      = n_c_ff[34] ? 35'(0) - n_c_ff : n_c_ff;
      reach_d_in = (m_c_ff != '0) && (n_c_ff <= m_wide) && (n_c_ff >= -m_wide);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         na_d_ff        <= n_abs[30:0];
         geo_d_ff.x     <= x_c_ff;
         geo_d_ff.y     <= y_c_ff;
         geo_d_ff.s     <= s_c_ff;
         geo_d_ff.n     <= n_c_ff[31:0];
         geo_d_ff.m     <= m_c_ff;
         geo_d_ff.reach <= reach_d_in;
      end
   end

   // stages e, f: m^2 - n^2
   logic [SQ_W-1:0] mm_e_ff, nn_e_ff, d_f_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mm_e_ff <= geo_d_ff.m * geo_d_ff.m;
         nn_e_ff <= na_d_ff * na_d_ff;
         d_f_ff  <= mm_e_ff - nn_e_ff;
      end
   end

   logic [SN_CELLS-1:0] sn_g;
   logic [RS_CELLS-1:0] rs_raw, rs_g;
   geo_type             geo_g;

   arm_ik_isqrt #(.W(SQ_W)) u_sin_root (
      .clock    (clock),
      .ce       (en),
      .radicand (d_f_ff),
      .root     (sn_g)
   );

   arm_ik_isqrt #(.W(RS_IN_W)) u_reach_root (
      .clock    (clock),
      .ce       (en),
      .radicand ({rr_b_ff, {(2 * FRAC_BITS){1'b0}}}),
      .root     (rs_raw)
   );

   arm_ik_delay #(.WIDTH(RS_CELLS), .DEPTH(RS_DLY)) u_rs_dly (
      .clock (clock),
      .ce    (en),
      .din   (rs_raw),
      .dout  (rs_g)
   );

   arm_ik_delay #(.WIDTH($bits(geo_type)), .DEPTH(SIDE_DLY)) u_geo_dly (
      .clock (clock),
      .ce    (en),
      .din   (geo_d_ff),
      .dout  (geo_g)
   );

   // stage h: products and cordic operands
   logic [COORD_W:0]            y_abs, s_abs;
   logic [45:0]                 pl2sn_h_ff, pl1m_h_ff;
   logic signed [47:0]          pl2n_h_ff;
   logic [CORDIC_W-1:0]         oy_h_ff [3];
   logic signed [CORDIC_W:0]    ox_h_ff [3];
   flag_type                    flag_h_ff;

   always_comb begin
      y_abs = geo_g.y[COORD_W-1] ? (COORD_W + 1)'(0) - geo_g.y : (COORD_W + 1)'(geo_g.y);
      s_abs = geo_g.s[COORD_W] ? (COORD_W + 1)'(0) - geo_g.s : geo_g.s;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pl2sn_h_ff      <= l2_ff * sn_g;
         pl1m_h_ff       <= l1_ff * geo_g.m;
         pl2n_h_ff       <= signed'({1'b0, l2_ff}) * geo_g.n;
         oy_h_ff[0]      <= CORDIC_W'(y_abs);
         ox_h_ff[0]      <= {{(CORDIC_W + 1 - COORD_W){geo_g.x[COORD_W-1]}}, geo_g.x};
         oy_h_ff[1]      <= CORDIC_W'(sn_g);
         ox_h_ff[1]      <= {{(CORDIC_W - 31){geo_g.n[31]}}, geo_g.n};
         oy_h_ff[2]      <= CORDIC_W'(s_abs) << FRAC_BITS;
         ox_h_ff[2]      <= (CORDIC_W + 1)'(rs_g);
         flag_h_ff.yneg  <= geo_g.y[COORD_W-1];
         flag_h_ff.sneg  <= geo_g.s[COORD_W];
         flag_h_ff.reach <= geo_g.reach;
      end
   end

   // stage i: cordic inputs
   logic [CORDIC_W-1:0]      cy_i_ff [4];
   logic signed [CORDIC_W:0] cx_i_ff [4];
   flag_type                 flag_i_ff, flag_c;
   logic [ANG_W-1:0]         ang [4];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int g = 0; g < 3; g++) begin
            cy_i_ff[g] <= oy_h_ff[g];
            cx_i_ff[g] <= ox_h_ff[g];
         end
         cy_i_ff[3] <= CORDIC_W'(pl2sn_h_ff);
         cx_i_ff[3] <= signed'({3'b000, pl1m_h_ff}) + {pl2n_h_ff[47], pl2n_h_ff};
         flag_i_ff  <= flag_h_ff;
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_cordic
      arm_ik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
         .clock (clock),
         .ce    (en),
         .y_mag (cy_i_ff[g]),
         .x_val (cx_i_ff[g]),
         .angle (ang[g])
      );
   end

   arm_ik_delay #(.WIDTH($bits(flag_type)), .DEPTH(CL)) u_flag_dly (
      .clock (clock),
      .ce    (en),
      .din   (flag_i_ff),
      .dout  (flag_c)
   );

   // stage j: ninety minus shoulder angle
   logic signed [26:0] ta_w, tb_w, v_j_in, v_j_ff;
   logic [7:0]         b_j_ff, e_j_ff;
   flag_type           flag_j_ff;

   always_comb begin
      ta_w   = signed'({3'b000, ang[2]});
      tb_w   = signed'({3'b000, ang[3]});
      v_j_in = signed'({3'b000, DEG90}) - tb_w + (flag_c.sneg ? ta_w : -ta_w);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_j_ff    <= v_j_in;
         b_j_ff    <= ang[0][ANG_W-1:ANG_FRAC];
         e_j_ff    <= ang[1][ANG_W-1:ANG_FRAC];
         flag_j_ff <= flag_c;
      end
   end

   // stage k: truncate toward zero, mask unreachable
   logic [26:0]      v_abs;
   logic [9:0]       sh_mag;
   logic [8:0]       base_in;
   logic [9:0]       sh_in;
   logic [OUT_W-1:0] fin_in, fin_ff;
   logic             reach_ff;

   always_comb begin
      v_abs   = v_j_ff[26] ? 27'(0) - v_j_ff : v_j_ff;
      sh_mag  = v_abs[25:16];
      sh_in   = v_j_ff[26] ? 10'(0) - sh_mag : sh_mag;
      base_in = flag_j_ff.yneg ? 9'(0) - {1'b0, b_j_ff} : {1'b0, b_j_ff};
      fin_in  = flag_j_ff.reach ? {e_j_ff, sh_in, base_in} : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff   <= fin_in;
         reach_ff <= flag_j_ff.reach;
      end
   end

   // output register and skid
   logic             out_vld_ff, skid_vld_ff;
   logic [OUT_W-1:0] out_data_ff, skid_data_ff;
   logic             out_user_ff, skid_user_ff;
   logic             out_take;

   assign en       = !skid_vld_ff;
   assign out_take = out_vld_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (en) begin
         if (!out_vld_ff || out_take) begin
            out_vld_ff <= vld_ff[PL-1];
         end else if (vld_ff[PL-1]) begin
            skid_vld_ff <= 1'b1;
         end
      end else if (out_take) begin
         skid_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (!out_vld_ff || out_take) begin
            out_data_ff <= fin_ff;
            out_user_ff <= reach_ff;
         end else begin
            skid_data_ff <= fin_ff;
            skid_user_ff <= reach_ff;
         end
      end else if (out_take) begin
         out_data_ff <= skid_data_ff;
         out_user_ff <= skid_user_ff;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(32 - OUT_W){1'b0}}, out_data_ff};
   assign rsp_tuser  = out_user_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds a response while output is empty");

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[26:0] == 27'd0)
      else $error("unreachable target with nonzero angles");

   a_elbow_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[26:19] <= 8'd180)
      else $error("elbow angle above 180");

   a_base_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (signed'(rsp_tdata[8:0]) >= -9'sd180) &&
                     (signed'(rsp_tdata[8:0]) <= 9'sd180))
      else $error("base angle out of range");

endmodule

`default_nettype wire

// ===== rtl/arm_ik_delay.sv =====
// arm_ik_delay: clock-enabled shift line that keeps side data aligned with the pipeline
// depends on nothing
`default_nettype none

module arm_ik_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             ce,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (ce) begin
         tap_ff[0] <= din;
      end
   end

   for (genvar k = 1; k < DEPTH; k++) begin : g_tap
      always_ff @(posedge clock) begin
         if (ce) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/arm_ik_isqrt.sv =====
// arm_ik_isqrt: integer square root as a row of cells, one result bit per cell
// depends on nothing
`default_nettype none

module arm_ik_isqrt #(
   parameter int W = 62
) (
   input  wire logic           clock,
   input  wire logic           ce,
   input  wire logic [W-1:0]   radicand,
   output logic      [W/2-1:0] root
);

   localparam int N = W / 2;

   logic [W-1:0] v_ff [N];
   logic [W-1:0] r_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_cell
      localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
      logic [W-1:0] v_prev;
      logic [W-1:0] r_prev;
      logic [W:0]   trial;
      logic [W-1:0] v_in;
      logic [W-1:0] r_in;

      if (k == 0) begin : g_first
         assign v_prev = radicand;
         assign r_prev = '0;
      end else begin : g_next
         assign v_prev = v_ff[k-1];
         assign r_prev = r_ff[k-1];
      end

      always_comb begin
         trial = {1'b0, r_prev} + {1'b0, BIT};
         if ({1'b0, v_prev} >= trial) begin
            v_in = v_prev - trial[W-1:0];
            r_in = (r_prev >> 1) + BIT;
         end else begin
            v_in = v_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            v_ff[k] <= v_in;
            r_ff[k] <= r_in;
         end
      end
   end

   assign root = r_ff[N-1][N-1:0];

endmodule

`default_nettype wire

// ===== rtl/arm_ik_cordic.sv =====
// arm_ik_cordic: pipelined vectoring cordic, angle of (x, |y|) in 0..180 degrees
// depends on arm_ik_pkg; normalizer stages, then a row of rotation cells
`default_nettype none

module arm_ik_cordic
   import arm_ik_pkg::*;
#(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       ce,
   input  wire logic [CORDIC_W-1:0]        y_mag,
   input  wire logic signed [CORDIC_W:0]   x_val,
   output logic      [ANG_W-1:0]           angle
);

   localparam int NS = 1 + NORM_RSH + NORM_LSH;

   logic [CORDIC_W-1:0] nx_ff [NS];
   logic [CORDIC_W-1:0] ny_ff [NS];
   logic                nneg_ff [NS];
   logic                nzero_ff [NS];

   logic [CORDIC_W:0]   xabs;

   // magnitude stage
   assign xabs = x_val[CORDIC_W] ? CORDIC_W'(0) - x_val : x_val;

   always_ff @(posedge clock) begin
      if (ce) begin
         nx_ff[0]    <= xabs[CORDIC_W-1:0];
         ny_ff[0]    <= y_mag;
         nneg_ff[0]  <= x_val[CORDIC_W];
         nzero_ff[0] <= (x_val == '0) && (y_mag == '0);
      end
   end

   // normalize so that the larger operand lies in [2^29, 2^30)
   for (genvar k = 1; k < NS; k++) begin : g_norm
      localparam bit RIGHT = (k <= NORM_RSH);
      localparam int AMT   = RIGHT ? (1 << (NORM_RSH - k)) : (1 << (NS - 1 - k));
      logic [CORDIC_W-1:0] both;
      logic                do_shift;
      logic [CORDIC_W-1:0] nx_in;
      logic [CORDIC_W-1:0] ny_in;

      always_comb begin
         both = nx_ff[k-1] | ny_ff[k-1];
         if (RIGHT) begin
            do_shift = (both >> (NORM_BITS - 1 + AMT)) != '0;
            nx_in    = do_shift ? nx_ff[k-1] >> AMT : nx_ff[k-1];
            ny_in    = do_shift ? ny_ff[k-1] >> AMT : ny_ff[k-1];
         end else begin
            do_shift = (both >> (NORM_BITS - AMT)) == '0;
            nx_in    = do_shift ? nx_ff[k-1] << AMT : nx_ff[k-1];
            ny_in    = do_shift ? ny_ff[k-1] << AMT : ny_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            nx_ff[k]    <= nx_in;
            ny_ff[k]    <= ny_in;
            nneg_ff[k]  <= nneg_ff[k-1];
            nzero_ff[k] <= nzero_ff[k-1];
         end
      end
   end

   logic signed [XY_W-1:0]  cx_ff [STAGES];
   logic signed [XY_W-1:0]  cy_ff [STAGES];
   logic signed [ACC_W-1:0] cz_ff [STAGES];
   logic                    cneg_ff [STAGES];
   logic                    czero_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      localparam logic signed [ACC_W-1:0] ATN = ACC_W'(ATAN_TAB[i]);
      logic signed [XY_W-1:0]  x_prev;
      logic signed [XY_W-1:0]  y_prev;
      logic signed [ACC_W-1:0] z_prev;
      logic                    neg_prev;
      logic                    zero_prev;
      logic signed [XY_W-1:0]  cx_in;
      logic signed [XY_W-1:0]  cy_in;
      logic signed [ACC_W-1:0] cz_in;

      if (i == 0) begin : g_first
         assign x_prev    = signed'(XY_W'(nx_ff[NS-1][NORM_BITS-1:0]));
         assign y_prev    = signed'(XY_W'(ny_ff[NS-1][NORM_BITS-1:0]));
         assign z_prev    = '0;
         assign neg_prev  = nneg_ff[NS-1];
         assign zero_prev = nzero_ff[NS-1];
      end else begin : g_next
         assign x_prev    = cx_ff[i-1];
         assign y_prev    = cy_ff[i-1];
         assign z_prev    = cz_ff[i-1];
         assign neg_prev  = cneg_ff[i-1];
         assign zero_prev = czero_ff[i-1];
      end

      always_comb begin
         if (!y_prev[XY_W-1]) begin
            cx_in = x_prev + (y_prev >>> i);
            cy_in = y_prev - (x_prev >>> i);
            cz_in = z_prev + ATN;
         end else begin
            cx_in = x_prev - (y_prev >>> i);
            cy_in = y_prev + (x_prev >>> i);
            cz_in = z_prev - ATN;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            cx_ff[i]    <= cx_in;
            cy_ff[i]    <= cy_in;
            cz_ff[i]    <= cz_in;
            cneg_ff[i]  <= neg_prev;
            czero_ff[i] <= zero_prev;
         end
      end
   end

   logic signed [ACC_W-1:0] zf;
   logic [ANG_W-1:0]        q1;
   logic [ANG_W-1:0]        angle_in;
   logic [ANG_W-1:0]        angle_ff;

   // clamp to the first quadrant, mirror for negative x
   always_comb begin
      zf = cz_ff[STAGES-1];
      if (czero_ff[STAGES-1] || zf[ACC_W-1]) begin
         q1 = '0;
      end else if (zf > signed'({1'b0, DEG90})) begin
         q1 = DEG90;
      end else begin
         q1 = zf[ANG_W-1:0];
      end
      angle_in = cneg_ff[STAGES-1] ? DEG180 - q1 : q1;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

`default_nettype wire

// ===== dv/arm_ik_checker.sv =====
// arm_ik_checker: watches the request and response streams of the arm ik block,
// computes the expected joint angles and compares them; depends on arm_ik_pkg
`timescale 1ns / 1ps

module arm_ik_checker
   import arm_ik_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [47:0]      req_tdata,
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [31:0]      rsp_tdata,
   input  wire logic             rsp_tuser,
   input  wire logic             csr_we,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [8:0] base;
      logic [9:0] shoulder;
      logic [7:0] elbow;
      logic       reach;
   } angles_type;

   localparam longint A90  = 64'd90 << 16;
   localparam longint A180 = 64'd180 << 16;

   longint     link1, link2, height;
   angles_type angle_q[$];
   longint     atan_lut[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

   function automatic longint floor_shift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint deg_trunc(longint v);
      if (v >= 0) return v >>> 16;
      return -((-v) >>> 16);
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   function automatic longint vec_angle_q1(longint unsigned yu, longint unsigned xu);
      longint unsigned mx;
      longint xv, yv, zv, dx, dy;
      mx = (xu > yu) ? xu : yu;
      zv = 0;
      if (mx == 0) return 0;
      while (mx >= (64'd1 << 30)) begin
         mx = mx >> 1; xu = xu >> 1; yu = yu >> 1;
      end
      while (mx < (64'd1 << 29)) begin
         mx = mx << 1; xu = xu << 1; yu = yu << 1;
      end
      xv = longint'(xu);
      yv = longint'(yu);
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
         dx = floor_shift(yv, i);
         dy = floor_shift(xv, i);
         if (yv >= 0) begin
            xv += dx; yv -= dy; zv += atan_lut[i];
         end else begin
            xv -= dx; yv += dy; zv -= atan_lut[i];
         end
      end
      if (zv < 0) zv = 0;
      if (zv > A90) zv = A90;
      return zv;
   endfunction

   function automatic longint half_plane_angle(longint unsigned ymag, longint xs);
      longint unsigned xm;
      longint a;
      xm = (xs < 0) ? longint'(-xs) : xs;
      a = vec_angle_q1(ymag, xm);
      return (xs < 0) ? A180 - a : a;
   endfunction

   function automatic angles_type solve_joints(logic [47:0] d);
      angles_type r;
      longint x, y, z, s, rr, m, n, sn, rs, ss, t1, t2, t3, ta, tb;
      x = longint'($signed(d[15:0]));
      y = longint'($signed(d[31:16]));
      z = longint'($signed(d[47:32]));
      s = z - height;
      rr = x * x + y * y;
      m = 2 * link1 * link2;
      n = rr + s * s - link1 * link1 - link2 * link2;
      r = '0;
      if (m == 0 || n > m || n < -m) return r;
      sn = int_sqrt(m * m - n * n);
      t1 = half_plane_angle((y < 0) ? -y : y, x);
      if (y < 0) t1 = -t1;
      t3 = half_plane_angle(sn, n);
      rs = int_sqrt(rr << 16);
      ss = s * 256;
      ta = half_plane_angle((ss < 0) ? -ss : ss, rs);
      if (ss < 0) ta = -ta;
      tb = half_plane_angle(link2 * sn, link1 * m + link2 * n);
      t2 = ta + tb;
      r.base = 9'(deg_trunc(t1));
      r.shoulder = 10'(deg_trunc(A90 - t2));
      r.elbow = 8'(deg_trunc(t3));
      r.reach = 1'b1;
      return r;
   endfunction

   assign pending = angle_q.size();

   always @(posedge clock) begin
      angles_type want, got;
      if (reset) begin
         link1 <= UPPER_ARM_RST;
         link2 <= FOREARM_RST;
         height <= SHOULDER_RST;
         angle_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_UPPER_ARM: link1 <= csr_wdata;
               CSR_FOREARM: link2 <= csr_wdata;
               CSR_SHOULDER: height <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[8:0], rsp_tdata[18:9], rsp_tdata[26:19], rsp_tuser};
            if (angle_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = angle_q.pop_front();
               if (got !== want || rsp_tdata[31:27] !== 5'd0) begin
                  if (fail_count < 10)
                     $display("mismatch base %0d/%0d shoulder %0d/%0d elbow %0d/%0d reach %b/%b",
                        $signed(want.base), $signed(got.base), $signed(want.shoulder),
                        $signed(got.shoulder), want.elbow, got.elbow, want.reach, got.reach);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) angle_q.push_back(solve_joints(req_tdata));
      end
   end

endmodule

// ===== dv/tb_top.sv =====
// tb_top: stimulus, reset and verdict for rrr_arm_inverse_kinematics
// depends on arm_ik_pkg, the block rtl and arm_ik_checker
`timescale 1ns / 1ps

module tb_top;
   import arm_ik_pkg::*;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [47:0]      req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [31:0]      rsp_tdata;
   logic             rsp_tuser;
   logic             csr_we = 0;
   logic [IDX_W-1:0] csr_index = CSR_UPPER_ARM;
   logic [CFG_W-1:0] csr_wdata = '0;
   int               fail_count, pending, quiet_cycles;
   bit               steady;

   rrr_arm_inverse_kinematics u_top (.*);

   arm_ik_checker u_chk (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (req_tvalid && req_tready || rsp_tvalid && rsp_tready) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("rrr_arm_inverse_kinematics verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 29);
   end

   task automatic write_reg(csr_index_type idx, logic [CFG_W-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic send_target(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      while (!steady && $urandom_range(99) < 29) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_all();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_coord(int reach);
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(2 * reach)) - reach);
      endcase
   endfunction

   task automatic random_phase(int count, int reach);
      for (int i = 0; i < count; i++) begin
         steady = (i > count / 2 && i < count / 2 + 60);
         send_target(pick_coord(reach), pick_coord(reach), pick_coord(reach));
      end
      steady = 0;
   endtask

   initial begin
      quiet_cycles = 0;
      steady = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, axis cases, folded and stretched arm
      send_target(16'd0, 16'd0, 16'd896);
      send_target(16'd2125, 16'd0, 16'd896);
      send_target(16'd1000, 16'd0, 16'd896);
      send_target(-16'sd1000, 16'd0, 16'd896);
      send_target(16'd0, 16'd1000, 16'd1500);
      send_target(16'd0, -16'sd1000, 16'd300);
      send_target(-16'sd1000, -16'sd500, 16'd896);
      send_target(16'd179, 16'd0, 16'd896);
      send_target(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_target(16'h8000, 16'h8000, 16'h8000);
      send_target(16'd0, 16'd0, 16'd0);
      send_target(16'd500, 16'd500, 16'd2000);
      drain_all();
      write_reg(CSR_UPPER_ARM, 15'd1000);
      write_reg(CSR_FOREARM, 15'd1000);
      write_reg(CSR_SHOULDER, 15'd0);
      send_target(16'd0, 16'd0, 16'd0);
      send_target(16'd2000, 16'd0, 16'd0);
      send_target(-16'sd2000, 16'd0, 16'd0);
      drain_all();
      random_phase(500, 3000);
      drain_all();
      write_reg(CSR_UPPER_ARM, 15'h7FFF);
      write_reg(CSR_FOREARM, 15'h7FFF);
      write_reg(CSR_SHOULDER, 15'h7FFF);
      random_phase(300, 32768);
      drain_all();
      write_reg(CSR_UPPER_ARM, 15'd1);
      write_reg(CSR_FOREARM, 15'd1);
      write_reg(CSR_SHOULDER, 15'd0);
      send_target(16'd0, 16'd0, 16'd0);
      send_target(16'd2, 16'd0, 16'd0);
      send_target(16'd1, 16'd1, 16'd0);
      random_phase(150, 3);
      drain_all();
      write_reg(CSR_UPPER_ARM, 15'($urandom_range(200, 4000)));
      write_reg(CSR_FOREARM, 15'($urandom_range(200, 4000)));
      write_reg(CSR_SHOULDER, 15'($urandom_range(0, 3000)));
      random_phase(600, 6000);
      drain_all();
      if (fail_count == 0) begin
         $display("rrr_arm_inverse_kinematics verification clean");
      end else begin
         $display("rrr_arm_inverse_kinematics verification failed");
      end
      $finish;
   end

endmodule
